>>> hw/rtl/nec_tx_pkg.sv
// Shared types and constants for the NEC infrared frame transmitter.
`timescale 1ns / 1ps
`default_nettype none

package nec_tx_pkg;

    // Width of the configuration write data; the widest register is a duration.
    localparam int unsigned CFG_DATA_W = 10;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned DUR_W      = 10;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ADDR_LOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ADDR_HIGH    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEAD_MARK    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LEAD_SPACE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_MARK     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_SPACE    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_SPACE   = 3'd6;

    // Reset values of the registers.
    localparam logic [7:0]       RST_ADDR_LOW   = 8'd3;
    localparam logic [7:0]       RST_ADDR_HIGH  = 8'd252;
    localparam logic [DUR_W-1:0] RST_LEAD_MARK  = 10'd346;
    localparam logic [DUR_W-1:0] RST_LEAD_SPACE = 10'd173;
    localparam logic [DUR_W-1:0] RST_BIT_MARK   = 10'd21;
    localparam logic [DUR_W-1:0] RST_ONE_SPACE  = 10'd64;
    localparam logic [DUR_W-1:0] RST_ZERO_SPACE = 10'd21;

    // Input item codes.
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_SEND = 1'b1;

    typedef struct packed {
        logic       cmd;
        logic [7:0] command_byte;
    } nec_tx_in_t;

    typedef struct packed {
        logic ir_level;
        logic busy_res;
        logic frame_done;
        logic rejected;
    } nec_tx_out_t;

endpackage

`default_nettype wire

>>> hw/rtl/nec_ir_frame_transmitter.sv
// NEC infrared frame transmitter: frame sequencer, configuration registers and result register.
`timescale 1ns / 1ps
`default_nettype none

// Tick-driven NEC transmitter. Each input beat is either a tick (cmd 0) or a send request
// (cmd 1) and produces exactly one result beat. A send while idle latches address and
// command and starts the frame; a send while a frame is running is flagged as rejected.
// Ticks play out leader mark, leader space, 32 bits LSB first and a stop burst, toggling
// ir_level on every tick of a mark. The block takes one beat per clock cycle: the frame
// sequencer updates its state in the accepting cycle and the result appears from the
// output register in the next cycle; it stalls only while that register is held by m_ready.
// Durations are in ticks; 0 acts as 1, and values beyond the tick counter saturate.
module nec_ir_frame_transmitter
    import nec_tx_pkg::*;
#(
    parameter int unsigned TICK_COUNT_WIDTH = 10
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire nec_tx_in_t            s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output nec_tx_out_t                m_data,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int unsigned TW    = TICK_COUNT_WIDTH;
    localparam int unsigned CMP_W = (TW > DUR_W) ? TW : DUR_W;
    localparam logic [CMP_W-1:0] COUNT_MAX = CMP_W'((64'd1 << TW) - 64'd1);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEAD_MARK,
        PH_LEAD_SPACE,
        PH_BIT_MARK,
        PH_BIT_SPACE,
        PH_STOP_MARK
    } phase_t;

    logic [7:0]       addr_low_reg;
    logic [7:0]       addr_high_reg;
    logic [DUR_W-1:0] lead_mark_reg;
    logic [DUR_W-1:0] lead_space_reg;
    logic [DUR_W-1:0] bit_mark_reg;
    logic [DUR_W-1:0] one_space_reg;
    logic [DUR_W-1:0] zero_space_reg;

    phase_t      phase_reg,    phase_next;
    logic [TW-1:0] tick_reg,   tick_next;
    logic [4:0]  bit_idx_reg,  bit_idx_next;
    logic [31:0] shift_reg,    shift_next;
    logic        carrier_reg,  carrier_next;

    logic        m_valid_reg;
    nec_tx_out_t m_data_reg;
    nec_tx_out_t res_next;

    logic             accept;
    logic [TW-1:0]    tick_inc;
    logic [DUR_W-1:0] dur_raw;
    logic [CMP_W-1:0] dur_len;
    logic             is_mark;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Duration of the current phase, with zero and oversize values clamped.
    always_comb begin
        unique case (phase_reg)
            PH_LEAD_MARK:  dur_raw = lead_mark_reg;
            PH_LEAD_SPACE: dur_raw = lead_space_reg;
            PH_BIT_SPACE:  dur_raw = shift_reg[0] ? one_space_reg : zero_space_reg;
            default:       dur_raw = bit_mark_reg;
        endcase
        dur_len = CMP_W'(dur_raw);
        if (dur_raw == '0) begin
            dur_len = CMP_W'(1);
        end else if (dur_len > COUNT_MAX) begin
            dur_len = COUNT_MAX;
        end
    end

    assign is_mark  = (phase_reg == PH_LEAD_MARK) || (phase_reg == PH_BIT_MARK)
                   || (phase_reg == PH_STOP_MARK);
    assign tick_inc = (tick_reg == '1) ? tick_reg : tick_reg + TW'(1);

    always_comb begin
        phase_next   = phase_reg;
        tick_next    = tick_reg;
        bit_idx_next = bit_idx_reg;
        shift_next   = shift_reg;
        carrier_next = carrier_reg;
        res_next     = '0;

        if (s_data.cmd == CMD_SEND) begin
            if (phase_reg != PH_IDLE) begin
                res_next.rejected = 1'b1;
            end else begin
                shift_next   = {~s_data.command_byte, s_data.command_byte,
                                addr_high_reg, addr_low_reg};
                phase_next   = PH_LEAD_MARK;
                tick_next    = '0;
                bit_idx_next = '0;
            end
        end else if (phase_reg == PH_IDLE) begin
            carrier_next = 1'b0;
        end else begin
            carrier_next = is_mark ? !carrier_reg : 1'b0;
            tick_next    = tick_inc;
            if (CMP_W'(tick_inc) >= dur_len) begin
                tick_next = '0;
                unique case (phase_reg)
                    PH_LEAD_MARK:  phase_next = PH_LEAD_SPACE;
                    PH_LEAD_SPACE: phase_next = PH_BIT_MARK;
                    PH_BIT_MARK:   phase_next = PH_BIT_SPACE;
                    PH_BIT_SPACE: begin
                        shift_next = {1'b0, shift_reg[31:1]};
                        if (bit_idx_reg == 5'd31) begin
                            bit_idx_next = '0;
                            phase_next   = PH_STOP_MARK;
                        end else begin
                            bit_idx_next = bit_idx_reg + 5'd1;
                            phase_next   = PH_BIT_MARK;
                        end
                    end
                    default: begin
                        phase_next          = PH_IDLE;
                        res_next.frame_done = 1'b1;
                    end
                endcase
            end
        end

        res_next.ir_level = carrier_next;
        res_next.busy_res = (phase_next != PH_IDLE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_low_reg   <= RST_ADDR_LOW;
            addr_high_reg  <= RST_ADDR_HIGH;
            lead_mark_reg  <= RST_LEAD_MARK;
            lead_space_reg <= RST_LEAD_SPACE;
            bit_mark_reg   <= RST_BIT_MARK;
            one_space_reg  <= RST_ONE_SPACE;
            zero_space_reg <= RST_ZERO_SPACE;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_ADDR_LOW:   addr_low_reg   <= cfg_data[7:0];
                REG_ADDR_HIGH:  addr_high_reg  <= cfg_data[7:0];
                REG_LEAD_MARK:  lead_mark_reg  <= cfg_data[DUR_W-1:0];
                REG_LEAD_SPACE: lead_space_reg <= cfg_data[DUR_W-1:0];
                REG_BIT_MARK:   bit_mark_reg   <= cfg_data[DUR_W-1:0];
                REG_ONE_SPACE:  one_space_reg  <= cfg_data[DUR_W-1:0];
                REG_ZERO_SPACE: zero_space_reg <= cfg_data[DUR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            tick_reg    <= '0;
            bit_idx_reg <= '0;
            shift_reg   <= '0;
            carrier_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg   <= phase_next;
                tick_reg    <= tick_next;
                bit_idx_reg <= bit_idx_next;
                shift_reg   <= shift_next;
                carrier_reg <= carrier_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= res_next;
        end
    end

    // A finished frame is never reported as still running.
    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_data.frame_done && m_data.busy_res))
        else $error("frame_done seen with busy_res set");

    // A rejected send only happens during a running frame.
    a_reject_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.rejected) |-> m_data.busy_res)
        else $error("rejected beat without a running frame");

    // Only a send request can be rejected.
    a_reject_send: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && res_next.rejected |-> s_data.cmd == CMD_SEND)
        else $error("tick beat flagged as rejected");

    // The tick and bit counters are parked at zero whenever no frame is running.
    a_idle_count: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_IDLE |-> (tick_reg == '0) && (bit_idx_reg == '0))
        else $error("tick or bit counter not cleared while idle");

    // A stalled result stays put until it is taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid && $stable(m_data))
        else $error("result register changed while stalled");

endmodule

`default_nettype wire
